### hw/rtl/selt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// selt_pkg
// Types, codes and sizes shared by the shared/exclusive lock table modules.
// ----------------------------------------------------------------------------
package selt_pkg;

   localparam int NUM_VARIABLES    = 32;
   localparam int NUM_TRANSACTIONS = 32;

   // The variable and transaction fields are 5 bits, so only the first 32
   // entries and transactions can ever be addressed.
   localparam int FIELD_REACH = 32;
   localparam int TABLE_DEPTH = (NUM_VARIABLES < FIELD_REACH) ? NUM_VARIABLES : FIELD_REACH;
   localparam int TABLE_IDX_W = $clog2(TABLE_DEPTH);
   localparam int HOLD_W      = NUM_TRANSACTIONS;
   localparam int TXN_REACH   = (HOLD_W < FIELD_REACH) ? HOLD_W : FIELD_REACH;
   localparam int MASK_OUT_W  = 32;
   localparam int MASK_LOW_W  = (HOLD_W < MASK_OUT_W) ? HOLD_W : MASK_OUT_W;

   // operation codes
   localparam logic [1:0] OP_QUERY       = 2'd0;
   localparam logic [1:0] OP_ACQUIRE     = 2'd1;
   localparam logic [1:0] OP_RELEASE_TXN = 2'd2;
   localparam logic [1:0] OP_RELEASE_ALL = 2'd3;

   // lock kinds
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // check result codes
   localparam logic [1:0] ST_CAN                = 2'd0;
   localparam logic [1:0] ST_CAN_IF_QUEUE_EMPTY = 2'd1;
   localparam logic [1:0] ST_SAME_WRITER        = 2'd2;
   localparam logic [1:0] ST_CANNOT             = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [4:0] variable;
      logic [4:0] transaction;
      logic       lock_kind;
   } req_type;

   typedef struct packed {
      logic [1:0]            read_status;
      logic [1:0]            write_status;
      logic [MASK_OUT_W-1:0] holder_mask;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
   } cmd_type;

endpackage
`default_nettype wire

### hw/rtl/selt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// selt_ctrl
// Handshake controller: tracks the output register and issues the load command.
// ----------------------------------------------------------------------------
module selt_ctrl
   import selt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output cmd_type      cmd
);

   localparam logic ST_EMPTY = 1'b0;
   localparam logic ST_FULL  = 1'b1;

   logic state_ff;
   logic state_in;
   logic load;

   // take a request whenever the output slot is free or is being drained
   assign req_ready = (state_ff == ST_EMPTY) || rsp_ready;
   assign load      = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_FULL);
   assign cmd.load  = load;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_EMPTY: begin
            if (load) state_in = ST_FULL;
         end
         ST_FULL: begin
            if (rsp_ready && !load) state_in = ST_EMPTY;
         end
         default: state_in = ST_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/selt_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// selt_datapath
// Lock table registers, read/write checks and the result register.
// ----------------------------------------------------------------------------
module selt_datapath
   import selt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   input  wire req_type req_data,
   output rsp_type      rsp_data
);

   logic [HOLD_W-1:0]     holders_ff  [TABLE_DEPTH];
   logic                  kind_ff     [TABLE_DEPTH];
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   logic                  valid_var;
   logic [TABLE_IDX_W-1:0] idx;
   logic [HOLD_W-1:0]     mask;
   logic                  kind;
   logic [HOLD_W-1:0]     txn_bit;
   logic                  txn_ok;
   logic                  member;
   logic [1:0]            rd_st;
   logic [1:0]            wr_st;
   logic [MASK_OUT_W-1:0] mask_low;

   assign valid_var = {1'b0, req_data.variable} < 6'(TABLE_DEPTH);
   assign idx       = req_data.variable[TABLE_IDX_W-1:0];
   assign mask      = valid_var ? holders_ff[idx] : '0;
   assign kind      = valid_var ? kind_ff[idx] : KIND_READ;

   always_comb begin
      txn_bit = '0;
      for (int i = 0; i < TXN_REACH; i++) begin
         txn_bit[i] = (req_data.transaction == 5'(i));
      end
   end

   assign txn_ok = |txn_bit;
   assign member = |(mask & txn_bit);

   always_comb begin
      rd_st = ST_CAN;
      wr_st = ST_CAN;
      if (mask != '0) begin
         if (kind == KIND_READ) rd_st = ST_CAN_IF_QUEUE_EMPTY;
         else if (member)       rd_st = ST_SAME_WRITER;
         else                   rd_st = ST_CANNOT;

         if (kind == KIND_READ && member && mask == txn_bit) wr_st = ST_CAN_IF_QUEUE_EMPTY;
         else if (kind == KIND_WRITE && member)               wr_st = ST_CAN;
         else                                                 wr_st = ST_CANNOT;
      end
   end

   always_comb begin
      mask_low = '0;
      for (int i = 0; i < MASK_LOW_W; i++) begin
         mask_low[i] = mask[i];
      end
   end

   always_comb begin
      rsp_in.read_status  = rd_st;
      rsp_in.write_status = wr_st;
      rsp_in.holder_mask  = mask_low;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   // table update, applied after the checks are taken from the old contents
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < TABLE_DEPTH; v++) begin
            holders_ff[v] <= '0;
            kind_ff[v]    <= KIND_READ;
         end
      end else if (cmd.load) begin
         case (req_data.op)
            OP_ACQUIRE: begin
               if (valid_var && txn_ok) begin
                  holders_ff[idx] <= mask | txn_bit;
                  kind_ff[idx]    <= req_data.lock_kind;
               end
            end
            OP_RELEASE_TXN: begin
               // drop the transaction's column in every entry, kinds stay
               for (int v = 0; v < TABLE_DEPTH; v++) begin
                  holders_ff[v] <= holders_ff[v] & ~txn_bit;
               end
            end
            OP_RELEASE_ALL: begin
               for (int v = 0; v < TABLE_DEPTH; v++) begin
                  holders_ff[v] <= '0;
                  kind_ff[v]    <= KIND_READ;
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule
`default_nettype wire

### hw/rtl/shared_exclusive_lock_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shared_exclusive_lock_table
// Read/write lock table with one holder mask and lock kind per variable.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid/req_ready    req_type (op, variable, ...)
//   rsp_      out         rsp_valid/rsp_ready    rsp_type (checks, holder mask)
//
// One request per cycle while the response is not stalled; its response appears in
// the cycle after acceptance, computed from the table before that request's update.
// The table lives in flip-flops, so a column release or a full clear updates
// every entry at once. Reset clears every entry to no holders and read kind.
// A stalled response holds the output register; a new request is taken in the
// same cycle the held response is drained.
// ----------------------------------------------------------------------------
module shared_exclusive_lock_table
   import selt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   cmd_type cmd;

   selt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   selt_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request produced no response");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

   a_free_slot_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("not ready with empty output register");

   a_load_matches_handshake: assert property (@(posedge clock) disable iff (reset)
      cmd.load == (req_valid && req_ready))
      else $error("load command out of step with request handshake");

endmodule
`default_nettype wire
